// File: hw/rtl/stream_frame_splitter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stream frame splitter
// Shared checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_FRAME_SPLITTER_TOP_DEFINES_SVH
`define STREAM_FRAME_SPLITTER_TOP_DEFINES_SVH

// Check that a property holds at every clock edge out of reset
`define SFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs out of reset
`define SFS_NEVER(lbl, cond, msg) \
  `SFS_ASSERT(lbl, !(cond), msg)

`endif

// File: hw/rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// Stream frame splitter package
// Shared widths, register indexes, framing modes and the queued word type.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  // Default sizing of the top level
  localparam int unsigned MAX_FRAME_DEF = 16777216;
  localparam int unsigned MAX_DELIM_DEF = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Field and counter widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned DLEN_W  = 4;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned ADJ_W   = 18;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0]  FIXED_LEN_RST = 17'd1;
  localparam logic [DLEN_W-1:0] DELIM_LEN_RST = 4'd1;
  localparam logic [CNT_W-1:0]  HDR_SIZE_RST  = 17'd4;
  localparam logic [CNT_W-1:0]  MAX_LEN_RST   = 17'd65536;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_DELIM  = 2'd1,
    MODE_LENGTH = 2'd2,
    MODE_NONE   = 2'd3
  } sfs_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_MODE  = 3'd0,
    REG_FIXED_LEN   = 3'd1,
    REG_DELIM_BYTES = 3'd2,
    REG_DELIM_LEN   = 3'd3,
    REG_HDR_SIZE    = 3'd4,
    REG_LEN_OFFSET  = 3'd5,
    REG_LEN_ADJUST  = 3'd6,
    REG_MAX_LEN     = 3'd7
  } sfs_reg_e;

  // One classified word
  typedef struct packed {
    logic              err;
    logic              last;
    logic [BYTE_W-1:0] data;
  } sfs_word_t;

  // Front to queue
  typedef struct packed {
    logic      valid;
    sfs_word_t word;
  } sfs_push_t;

  // Queue head toward the back
  typedef struct packed {
    logic      valid;
    sfs_word_t word;
  } sfs_head_t;

endpackage

`default_nettype wire

// File: hw/rtl/stream_frame_splitter_top.sv
// ----------------------------------------------------------------------------
// Stream frame splitter
// Passes a byte stream through one byte per word and marks frame ends.
//
// Frames are found in fixed-length, delimiter or length-field mode; an
// illegal length-field size sets tuser together with tlast and framing
// restarts on the next byte. The block takes one byte every cycle while
// the queue has room; an accepted byte passes through the queue and the
// output register. The rate is set by the front's combinational classify
// path (length-field add and size compare), and a four-word queue plus
// the output register absorb output stalls. Configuration writes take
// effect on the next byte and do not clear the frame counters.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_frame_splitter_top #(
  parameter int unsigned MaxFrame     = sfs_pkg::MAX_FRAME_DEF,
  parameter int unsigned MaxDelimiter = sfs_pkg::MAX_DELIM_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [sfs_pkg::BYTE_W-1:0]     s_axis_tdata_i,  // [7:0] data_byte
  // Output stream
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output      logic [sfs_pkg::BYTE_W-1:0]     m_axis_tdata_o,  // [7:0] out_byte
  output      logic                           m_axis_tlast_o,  // frame_end
  output      logic                           m_axis_tuser_o   // [0] frame_error
);
  import sfs_pkg::*;

  sfs_push_t push;
  sfs_head_t head;
  logic      full;
  logic      pop;

  // Accept and classify
  sfs_front #(
    .MaxFrame     (MaxFrame),
    .MaxDelimiter (MaxDelimiter)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .full_i      (full),
    .push_o      (push)
  );

  // Decouple front and back
  sfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Drive the output stream
  sfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sfs_front.sv
// ----------------------------------------------------------------------------
// Stream frame splitter front
// Holds configuration, accepts input words and marks frame ends and errors.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_frame_splitter_top_defines.svh"

module sfs_front #(
  parameter int unsigned MaxFrame     = sfs_pkg::MAX_FRAME_DEF,
  parameter int unsigned MaxDelimiter = sfs_pkg::MAX_DELIM_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                          s_tvalid_i,
  output      logic                          s_tready_o,
  input  wire logic [sfs_pkg::BYTE_W-1:0]    s_tdata_i,
  input  wire logic                          full_i,
  output      sfs_pkg::sfs_push_t            push_o
);
  import sfs_pkg::*;

  localparam int unsigned DelimW = 8 * MaxDelimiter;
  localparam int unsigned FsW    = 35;
  localparam logic [CNT_W-1:0] CntMax = '1;

  // Configuration registers
  sfs_mode_e          cfg_mode_q;
  logic [CNT_W-1:0]   cfg_fixed_q;
  logic [DelimW-1:0]  cfg_delim_q;
  logic [DLEN_W-1:0]  cfg_dlen_q;
  logic [CNT_W-1:0]   cfg_hdr_q;
  logic [OFF_W-1:0]   cfg_off_q;
  logic signed [ADJ_W-1:0] cfg_adj_q;
  logic [CNT_W-1:0]   cfg_max_q;

  // Framing state
  logic [CNT_W-1:0]   bytes_q, bytes_d;
  logic [DelimW-1:0]  recent_q, recent_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   target_q, target_d;
  logic               known_q, known_d;

  logic                    accept;
  logic [CNT_W-1:0]        count;
  logic [DelimW+7:0]       shift_c;
  logic [DLEN_W-1:0]       dlen;
  logic [MaxDelimiter-1:0] byte_ok;
  logic [CNT_W-1:0]        off_ext;
  logic [CNT_W-1:0]        field_end;
  logic [CNT_W-1:0]        hdr_end;
  logic                    in_field;
  logic [LEN_W-1:0]        len_next;
  logic signed [FsW-1:0]   fs;
  logic                    fs_bad;
  logic                    last;
  logic                    err;

  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && !full_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q  <= MODE_FIXED;
      cfg_fixed_q <= FIXED_LEN_RST;
      cfg_delim_q <= '0;
      cfg_dlen_q  <= DELIM_LEN_RST;
      cfg_hdr_q   <= HDR_SIZE_RST;
      cfg_off_q   <= '0;
      cfg_adj_q   <= '0;
      cfg_max_q   <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (sfs_reg_e'(cfg_index_i))
        REG_FRAME_MODE:  cfg_mode_q  <= sfs_mode_e'(cfg_wdata_i[1:0]);
        REG_FIXED_LEN:   cfg_fixed_q <= cfg_wdata_i[CNT_W-1:0];
        REG_DELIM_BYTES: cfg_delim_q <= cfg_wdata_i[DelimW-1:0];
        REG_DELIM_LEN:   cfg_dlen_q  <= cfg_wdata_i[DLEN_W-1:0];
        REG_HDR_SIZE:    cfg_hdr_q   <= cfg_wdata_i[CNT_W-1:0];
        REG_LEN_OFFSET:  cfg_off_q   <= cfg_wdata_i[OFF_W-1:0];
        REG_LEN_ADJUST:  cfg_adj_q   <= $signed(cfg_wdata_i[ADJ_W-1:0]);
        REG_MAX_LEN:     cfg_max_q   <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Count this byte, saturating, and shift it into the history
  assign count    = (bytes_q == CntMax) ? bytes_q : bytes_q + 1'b1;
  assign shift_c  = {recent_q, s_tdata_i};
  assign recent_d = shift_c[DelimW-1:0];

  // Clamp delimiter length into the supported range
  always_comb begin
    if (cfg_dlen_q == '0) begin
      dlen = 4'd1;
    end else if (cfg_dlen_q > DLEN_W'(MaxDelimiter)) begin
      dlen = DLEN_W'(MaxDelimiter);
    end else begin
      dlen = cfg_dlen_q;
    end
  end

  // Compare each history byte against the delimiter, ignoring unused bytes
  always_comb begin
    for (int i = 0; i < MaxDelimiter; i++) begin
      byte_ok[i] = (DLEN_W'(i) >= dlen) ||
                   (recent_d[8*i +: 8] == cfg_delim_q[8*i +: 8]);
    end
  end

  // Length field collection and frame size check
  assign off_ext   = {1'b0, cfg_off_q};
  assign field_end = off_ext + 17'd4;
  assign hdr_end   = (cfg_hdr_q > field_end) ? cfg_hdr_q : field_end;
  assign in_field  = (bytes_q >= off_ext) && (bytes_q < field_end);
  assign len_next  = in_field ? {len_q[LEN_W-9:0], s_tdata_i} : len_q;

  assign fs = $signed({{(FsW-CNT_W){1'b0}}, cfg_hdr_q}) +
              $signed({{(FsW-LEN_W){1'b0}}, len_next}) +
              FsW'(cfg_adj_q);

  assign fs_bad = (fs < $signed({{(FsW-CNT_W){1'b0}}, hdr_end})) ||
                  (fs > $signed({{(FsW-CNT_W){1'b0}}, cfg_max_q})) ||
                  (fs > $signed(FsW'(MaxFrame)));

  // Classify the byte and advance the framing state
  always_comb begin
    bytes_d  = bytes_q;
    len_d    = len_q;
    target_d = target_q;
    known_d  = known_q;
    last     = 1'b0;
    err      = 1'b0;
    unique case (cfg_mode_q)
      MODE_FIXED: begin
        bytes_d = count;
        last    = (count >= cfg_fixed_q);
      end
      MODE_DELIM: begin
        bytes_d = count;
        last    = (&byte_ok) && (count >= CNT_W'(dlen));
      end
      MODE_LENGTH: begin
        bytes_d = count;
        if (!known_q) begin
          len_d = len_next;
          if (count >= hdr_end) begin
            if (fs_bad) begin
              err  = 1'b1;
              last = 1'b1;
            end else begin
              target_d = fs[CNT_W-1:0];
              known_d  = 1'b1;
              last     = (count >= fs[CNT_W-1:0]);
            end
          end
        end else begin
          last = (count >= target_q);
        end
      end
      MODE_NONE: begin
        bytes_d = bytes_q;
      end
      default: ;
    endcase
    // Restart framing after the last byte
    if (last) begin
      bytes_d  = '0;
      len_d    = '0;
      target_d = '0;
      known_d  = 1'b0;
    end
  end

  // Update state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q  <= '0;
      recent_q <= '0;
      len_q    <= '0;
      target_q <= '0;
      known_q  <= 1'b0;
    end else if (accept) begin
      bytes_q  <= bytes_d;
      recent_q <= recent_d;
      len_q    <= len_d;
      target_q <= target_d;
      known_q  <= known_d;
    end
  end

  // Push the classified word
  always_comb begin
    push_o.valid     = accept;
    push_o.word.err  = err;
    push_o.word.last = last;
    push_o.word.data = s_tdata_i;
  end

  `SFS_ASSERT(a_err_ends_frame, (push_o.valid && push_o.word.err) |-> push_o.word.last, "error word not marked last")
  `SFS_NEVER(a_target_floor, known_q && (target_q < 17'd4), "frame size below minimum header")
  `SFS_ASSERT(a_restart_clears, (accept && last) |=> (bytes_q == '0 && !known_q), "framing not restarted")

endmodule

`default_nettype wire

// File: hw/rtl/sfs_queue.sv
// ----------------------------------------------------------------------------
// Stream frame splitter queue
// Short word queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_frame_splitter_top_defines.svh"

module sfs_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfs_pkg::sfs_push_t push_i,
  output      logic               full_o,
  output      sfs_pkg::sfs_head_t head_o,
  input  wire logic               pop_i
);
  import sfs_pkg::*;

  sfs_word_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o = (count_q == QCNT_W'(QUEUE_DEPTH));

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.word;
    end
  end

  // Track fill level and pointers
  assign count_d = count_q + QCNT_W'(push_i.valid) - QCNT_W'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // Present the oldest word
  assign head_o.valid = (count_q != '0);
  assign head_o.word  = mem_q[rd_ptr_q];

  `SFS_ASSERT(a_no_overflow, push_i.valid |-> !full_o, "push into full queue")
  `SFS_ASSERT(a_no_underflow, pop_i |-> head_o.valid, "pop from empty queue")
  `SFS_ASSERT(a_count_grows, (push_i.valid && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "queue count lost a push")

endmodule

`default_nettype wire

// File: hw/rtl/sfs_back.sv
// ----------------------------------------------------------------------------
// Stream frame splitter back
// Output register that drains the queue onto the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire sfs_pkg::sfs_head_t         head_i,
  output      logic                       pop_o,
  output      logic                       m_tvalid_o,
  input  wire logic                       m_tready_i,
  output      logic [sfs_pkg::BYTE_W-1:0] m_tdata_o,
  output      logic                       m_tlast_o,
  output      logic                       m_tuser_o
);
  import sfs_pkg::*;

  logic      out_valid_q;
  sfs_word_t out_word_q;

  // Load a new word when the register is empty or being taken
  assign pop_o = head_i.valid && (!out_valid_q || m_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_word_q <= head_i.word;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_word_q.data;
  assign m_tlast_o  = out_word_q.last;
  assign m_tuser_o  = out_word_q.err;

endmodule

`default_nettype wire
